### rtl/annexb_access_unit_splitter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the access unit splitter RTL.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is asserted
`define AUS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check with no reset qualifier
`define AUS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AUS_ASSERT(lbl, clk, rstn, prop, msg)
`define AUS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg
// Types and constants of the Annex-B access unit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package aus_pkg;

  localparam int unsigned PosW      = 32;  // stream offsets, wrap modulo 2^32
  localparam int unsigned CountW    = 32;  // unit counter
  localparam int unsigned SkipW     = 20;  // skip_count register
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NalTypeW  = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned RegIdxW   = ApbAddrW - 2;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  // register index map
  localparam logic [RegIdxW-1:0] RegSkipCount = RegIdxW'(0);

  // NAL unit types
  localparam logic [NalTypeW-1:0] NalTypeIdr      = 5'd5;
  localparam logic [NalTypeW-1:0] NalTypeSps      = 5'd7;
  localparam logic [NalTypeW-1:0] NalTypeSliceMin = 5'd1;
  localparam logic [NalTypeW-1:0] NalTypeSliceMax = 5'd5;

  localparam logic [ByteW-1:0] ZeroByte      = 8'h00;
  localparam logic [ByteW-1:0] StartCodeByte = 8'h01;

  localparam logic [1:0] ZeroRunMax  = 2'd3;
  localparam logic [1:0] ZeroRunCode = 2'd2;

  typedef struct packed {
    logic [PosW-1:0]   au_offset;
    logic [PosW-1:0]   au_length;
    logic              key_frame;
    logic [CountW-1:0] unit_index;
    logic              last_of_run;
  } aus_result_t;

  // writes into the result queue from one parse step
  typedef struct packed {
    logic v0;  // slot 0 carries a result
    logic v1;  // slot 1 carries a result (only with slot 0)
  } aus_push_t;

endpackage

`default_nettype wire

### rtl/aus_in_if.sv
// ----------------------------------------------------------------------------
// aus_in_if
// Byte stream channel: valid/ready handshake with one stream byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface aus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

### rtl/aus_out_if.sv
// ----------------------------------------------------------------------------
// aus_out_if
// Access unit channel: valid/ready handshake with one access unit per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface aus_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] au_offset;
  logic [31:0] au_length;
  logic        key_frame;
  logic [31:0] unit_index;
  logic        last_of_run;

  modport source (output valid, output au_offset, output au_length, output key_frame,
                  output unit_index, output last_of_run, input ready);
  modport sink   (input valid, input au_offset, input au_length, input key_frame,
                  input unit_index, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/aus_fifo.sv
// ----------------------------------------------------------------------------
// aus_fifo
// Result queue: takes up to two access units per cycle, sends one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "annexb_access_unit_splitter_macros.svh"

module aus_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aus_pkg::aus_push_t  push_i,
  input  aus_pkg::aus_result_t res0_i,
  input  aus_pkg::aus_result_t res1_i,
  output logic                room_o,
  aus_out_if.source           out_o
);
  import aus_pkg::*;

  aus_result_t      mem_q [FifoDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [PtrW-1:0]  wptr_nxt;
  logic             pop;
  aus_result_t      head;

  assign pop      = out_o.valid && out_o.ready;
  assign wptr_nxt = wptr_q + PtrW'(1);
  assign room_o   = (fill_q <= FillW'(FifoDepth - 2));

  always_comb begin
    wptr_d = wptr_q + PtrW'(push_i.v0) + PtrW'(push_i.v1);
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    fill_d = fill_q + FillW'(push_i.v0) + FillW'(push_i.v1) - FillW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wptr_q] <= res0_i;
    end
    if (push_i.v1) begin
      mem_q[wptr_nxt] <= res1_i;
    end
  end

  assign head              = mem_q[rptr_q];
  assign out_o.valid       = (fill_q != '0);
  assign out_o.au_offset   = head.au_offset;
  assign out_o.au_length   = head.au_length;
  assign out_o.key_frame   = head.key_frame;
  assign out_o.unit_index  = head.unit_index;
  assign out_o.last_of_run = head.last_of_run;

  `AUS_ASSERT(a_push_needs_room, clk_i, rst_ni, push_i.v0 |-> room_o, "push without room")
  `AUS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillW'(FifoDepth), "queue overfilled")

endmodule

`default_nettype wire

### rtl/aus_parse.sv
// ----------------------------------------------------------------------------
// aus_parse
// Input register plus start code scan, access unit grouping and skip and key filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "annexb_access_unit_splitter_macros.svh"

module aus_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  aus_in_if.sink                      in_i,
  input  logic [aus_pkg::SkipW-1:0]   skip_count_i,
  input  logic                        room_i,
  output aus_pkg::aus_push_t          push_o,
  output aus_pkg::aus_result_t        res0_o,
  output aus_pkg::aus_result_t        res1_o
);
  import aus_pkg::*;

  // input register
  logic              s_valid_q;
  logic [ByteW-1:0]  s_byte_q;
  logic              s_eos_q;
  logic              step;

  // parser state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [1:0]        zrun_q, zrun_d;
  logic              hdr_q, hdr_d;
  logic [PosW-1:0]   pend_q, pend_d;
  logic              open_q, open_d;
  logic [PosW-1:0]   start_q, start_d;
  logic              slice_q, slice_d;
  logic              ukey_q, ukey_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              armed_q, armed_d;

  logic [NalTypeW-1:0] hdr_type;
  logic                nal_key, nal_vcl;
  logic                close_unit, emit0, emit1, armed_n;
  logic [CountW-1:0]   cnt_a, cnt_b, cnt_fin, skip_ext;
  aus_result_t         r_close, r_eos;

  assign step       = s_valid_q && room_i;
  assign in_i.ready = !s_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s_byte_q <= in_i.data_byte;
      s_eos_q  <= in_i.end_of_stream;
    end
  end

  assign hdr_type = s_byte_q[NalTypeW-1:0];
  assign nal_key  = (hdr_type == NalTypeIdr) || (hdr_type == NalTypeSps);
  assign nal_vcl  = hdr_type inside {[NalTypeSliceMin:NalTypeSliceMax]};
  assign skip_ext = CountW'(skip_count_i);
  assign cnt_a    = cnt_q + CountW'(1);
  assign cnt_b    = cnt_q + CountW'(2);

  always_comb begin
    pos_d      = pos_q;
    zrun_d     = zrun_q;
    hdr_d      = hdr_q;
    pend_d     = pend_q;
    open_d     = open_q;
    start_d    = start_q;
    slice_d    = slice_q;
    ukey_d     = ukey_q;
    cnt_d      = cnt_q;
    armed_d    = armed_q;
    close_unit = 1'b0;
    emit0      = 1'b0;
    emit1      = 1'b0;
    armed_n    = armed_q;
    cnt_fin    = cnt_a;

    if (step) begin
      if (hdr_q) begin
        hdr_d  = 1'b0;
        zrun_d = '0;
        if (open_q && slice_q) begin
          // header after the unit's slice: close it, open the next
          close_unit = 1'b1;
          start_d    = pend_q;
          ukey_d     = nal_key;
          slice_d    = nal_vcl;
        end else if (open_q) begin
          ukey_d  = ukey_q || nal_key;
          slice_d = slice_q || nal_vcl;
        end else begin
          open_d  = 1'b1;
          start_d = pend_q;
          ukey_d  = nal_key;
          slice_d = nal_vcl;
        end
      end else if (s_byte_q == ZeroByte) begin
        if (zrun_q != ZeroRunMax) begin
          zrun_d = zrun_q + 2'd1;
        end
      end else begin
        if (s_byte_q == StartCodeByte && zrun_q >= ZeroRunCode && !s_eos_q) begin
          pend_d = pos_q - ((zrun_q == ZeroRunMax) ? PosW'(3) : PosW'(2));
          hdr_d  = 1'b1;
        end
        zrun_d = '0;
      end

      // skip and key filter for the closed unit
      if (close_unit && cnt_a > skip_ext && (armed_q || ukey_q)) begin
        emit0   = 1'b1;
        armed_n = 1'b1;
      end
      cnt_d = close_unit ? cnt_a : cnt_q;

      // end of stream flushes the open unit
      cnt_fin = close_unit ? cnt_b : cnt_a;
      if (s_eos_q && open_d && cnt_fin > skip_ext && (armed_n || ukey_d)) begin
        emit1   = 1'b1;
        armed_n = 1'b1;
      end
      armed_d = armed_n;

      if (s_eos_q) begin
        pos_d   = '0;
        zrun_d  = '0;
        hdr_d   = 1'b0;
        pend_d  = '0;
        open_d  = 1'b0;
        start_d = '0;
        slice_d = 1'b0;
        ukey_d  = 1'b0;
        cnt_d   = '0;
        armed_d = 1'b0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_comb begin
    r_close.au_offset   = start_q;
    r_close.au_length   = pend_q - start_q;
    r_close.key_frame   = ukey_q;
    r_close.unit_index  = cnt_a;
    r_close.last_of_run = !emit1;

    // open unit as it stands after this byte's header update
    r_eos.au_offset   = (hdr_q && (close_unit || !open_q)) ? pend_q : start_q;
    r_eos.au_length   = pos_q + PosW'(1) - r_eos.au_offset;
    r_eos.key_frame   = (hdr_q && (close_unit || !open_q)) ? nal_key :
                        (ukey_q || (hdr_q && nal_key));
    r_eos.unit_index  = cnt_fin;
    r_eos.last_of_run = 1'b1;

    push_o = '0;
    res0_o = r_close;
    res1_o = r_eos;
    if (emit0) begin
      push_o.v0 = 1'b1;
      push_o.v1 = emit1;
    end else if (emit1) begin
      push_o.v0 = 1'b1;
      res0_o    = r_eos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      zrun_q  <= '0;
      hdr_q   <= 1'b0;
      pend_q  <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
      slice_q <= 1'b0;
      ukey_q  <= 1'b0;
      cnt_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      zrun_q  <= zrun_d;
      hdr_q   <= hdr_d;
      pend_q  <= pend_d;
      open_q  <= open_d;
      start_q <= start_d;
      slice_q <= slice_d;
      ukey_q  <= ukey_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
    end
  end

  `AUS_ASSERT(a_hdr_clears_run, clk_i, rst_ni, hdr_q |-> (zrun_q == '0), "zero run kept past start code")
  `AUS_ASSERT(a_closed_unit_idle, clk_i, rst_ni, !open_q |-> (!slice_q && !ukey_q), "unit flags without open unit")
  `AUS_ASSERT(a_eos_resets, clk_i, rst_ni, (step && s_eos_q) |=> (pos_q == '0 && !open_q && !hdr_q && cnt_q == '0), "state kept after end of stream")

endmodule

`default_nettype wire

### rtl/annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// Splits an H.264 Annex-B byte stream into access units with skip and key gate.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one stream byte per transfer; end_of_stream marks the last
//   byte, which flushes the open access unit and returns the parser to reset.
//   out_o carries one access unit per transfer (offset, length, key flag,
//   1-based unit index, last_of_run). One byte closes at most two units.
//   skip_count is written through the APB port at address 0; the user must
//   write it only while idle, the block itself does not enforce this.
// Timing:
//   A byte is registered in the input register and parsed into a four-entry
//   result queue when the queue has room; its results show on out_o from the
//   queue. One byte per cycle is sustained while the queue has room; the
//   only limit is the result queue, which must hold room for two units.
// Reset and stalls:
//   Reset clears the parser, the queue and skip_count. When the receiver
//   stalls, results collect in the queue; once it holds three entries the
//   byte in the input register waits and in_i ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_access_unit_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  aus_in_if.sink                        in_i,
  aus_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aus_pkg::ApbAddrW-1:0]  paddr,
  input  logic [aus_pkg::ApbDataW-1:0]  pwdata,
  output logic [aus_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import aus_pkg::*;

  logic [SkipW-1:0] skip_q;
  logic             reg_hit;
  logic             room;
  aus_push_t        push;
  aus_result_t      res0, res1;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ApbAddrW-1:2] == RegSkipCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      skip_q <= pwdata[SkipW-1:0];
    end
  end

  assign prdata = reg_hit ? ApbDataW'(skip_q) : '0;

  aus_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .skip_count_i (skip_q),
    .room_i       (room),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  aus_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res0_i (res0),
    .res1_i (res1),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### dv/annexb_access_unit_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_tb
// Feeds Annex-B byte streams into the splitter and checks every access unit.
// A behavioral parser runs beside the block on each accepted byte and queues
// the units it should emit; every unit from the block is matched in order
// against that queue. Coverage comes from directed corner streams, random
// well-formed streams with some noise, several skip settings, random idling
// on both sides, and a long receiver stall.
// ----------------------------------------------------------------------------

module annexb_access_unit_splitter_tb;
  import aus_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 10;
  localparam int unsigned LongStall   = 300;

  localparam logic [ApbAddrW-1:0] SkipCountAddr = ApbAddrW'({RegSkipCount, 2'b00});
  localparam logic [ApbAddrW-1:0] UnmappedAddr  = ApbAddrW'(4);
  localparam logic [SkipW-1:0]    SkipMax       = '1;

  // non-VCL types used to build realistic parameter and SEI units
  localparam logic [NalTypeW-1:0] NalTypeSei = 5'd6;
  localparam logic [NalTypeW-1:0] NalTypePps = 5'd8;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  aus_in_if  in_if ();
  aus_out_if out_if ();

  annexb_access_unit_splitter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // parser state mirrored from the block
  logic [SkipW-1:0]  skip_units;
  logic [PosW-1:0]   stream_pos;
  logic [1:0]        zero_count;
  logic              expect_header;
  logic [PosW-1:0]   code_offset;
  logic              au_open;
  logic [PosW-1:0]   au_start;
  logic              au_has_slice;
  logic              au_is_key;
  logic [CountW-1:0] au_count;
  logic              key_seen;

  aus_result_t au_expected[$];
  int          step_results;
  int          mismatch_count;
  logic [7:0]  stream_q[$];
  bit          quiet_sender;
  bit          quiet_receiver;
  int unsigned hold_request;

  function automatic void clear_parser();
    stream_pos    = '0;
    zero_count    = '0;
    expect_header = 1'b0;
    code_offset   = '0;
    au_open       = 1'b0;
    au_start      = '0;
    au_has_slice  = 1'b0;
    au_is_key     = 1'b0;
    au_count      = '0;
    key_seen      = 1'b0;
  endfunction

  // count one closed unit and queue it if it passes the skip and key gate
  function automatic void account_unit(logic [PosW-1:0] start, logic [PosW-1:0] len,
                                       logic key);
    aus_result_t r;
    au_count = au_count + CountW'(1);
    if (au_count <= CountW'(skip_units)) return;
    if (!key_seen) begin
      if (!key) return;
      key_seen = 1'b1;
    end
    if (step_results >= 2) return;
    r.au_offset   = start;
    r.au_length   = len;
    r.key_frame   = key;
    r.unit_index  = au_count;
    r.last_of_run = 1'b0;
    au_expected.push_back(r);
    step_results++;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eos);
    logic [NalTypeW-1:0] hdr_type;
    logic                is_key;
    logic                is_vcl;
    aus_result_t         tail;
    step_results = 0;
    if (expect_header) begin
      hdr_type      = b[NalTypeW-1:0];
      is_key        = (hdr_type == NalTypeIdr) || (hdr_type == NalTypeSps);
      is_vcl        = (hdr_type >= NalTypeSliceMin) && (hdr_type <= NalTypeSliceMax);
      expect_header = 1'b0;
      zero_count    = '0;
      if (au_open && au_has_slice) begin
        account_unit(au_start, code_offset - au_start, au_is_key);
        au_start     = code_offset;
        au_is_key    = is_key;
        au_has_slice = is_vcl;
      end else if (au_open) begin
        au_is_key    = au_is_key || is_key;
        au_has_slice = au_has_slice || is_vcl;
      end else begin
        au_open      = 1'b1;
        au_start     = code_offset;
        au_is_key    = is_key;
        au_has_slice = is_vcl;
      end
    end else if (b == ZeroByte) begin
      if (zero_count < ZeroRunMax) zero_count = zero_count + 2'd1;
    end else begin
      // a 01 on the last byte cannot be followed by a header
      if (b == StartCodeByte && zero_count >= ZeroRunCode && !eos) begin
        code_offset   = stream_pos - ((zero_count >= ZeroRunMax) ? 32'd3 : 32'd2);
        expect_header = 1'b1;
      end
      zero_count = '0;
    end
    if (eos) begin
      if (au_open) account_unit(au_start, stream_pos + PosW'(1) - au_start, au_is_key);
      clear_parser();
    end else begin
      stream_pos = stream_pos + PosW'(1);
    end
    if (step_results > 0) begin
      tail = au_expected.pop_back();
      tail.last_of_run = 1'b1;
      au_expected.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_au
    aus_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (au_expected.size() == 0) begin
        $display("%0t: unexpected unit, expected none, actual offset %0h length %0h index %0h",
                 $time, out_if.au_offset, out_if.au_length, out_if.unit_index);
        mismatch_count++;
      end else begin
        want = au_expected.pop_front();
        check_field("au_offset", want.au_offset, out_if.au_offset);
        check_field("au_length", want.au_length, out_if.au_length);
        check_field("key_frame", 32'(want.key_frame), 32'(out_if.key_frame));
        check_field("unit_index", want.unit_index, out_if.unit_index);
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_if.last_of_run));
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted here when requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      out_if.ready <= quiet_receiver || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic write_reg(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[ApbAddrW-1:2] == RegSkipCount) skip_units = value[SkipW-1:0];
  endtask

  // hold valid while the next byte follows; drop it only for a gap
  task automatic send_byte(logic [7:0] b, logic eos);
    while (!quiet_sender && $urandom_range(0, 99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_stream <= eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_byte(b, eos);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (au_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void add_start_code(int zeros);
    repeat (zeros) stream_q.push_back(ZeroByte);
    stream_q.push_back(StartCodeByte);
  endfunction

  function automatic void add_payload(int len);
    int unsigned pick;
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) stream_q.push_back(ZeroByte);
      else if (pick < 20) stream_q.push_back(StartCodeByte);
      else stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic logic [7:0] random_header();
    int unsigned         pick;
    logic [NalTypeW-1:0] hdr_type;
    logic [2:0]          upper;
    pick  = $urandom_range(0, 99);
    upper = 3'($urandom_range(0, 7));
    if (pick < 30) hdr_type = NalTypeSliceMin;
    else if (pick < 45) hdr_type = NalTypeIdr;
    else if (pick < 55) hdr_type = NalTypeSps;
    else if (pick < 65) hdr_type = NalTypePps;
    else if (pick < 72) hdr_type = NalTypeSei;
    else hdr_type = NalTypeW'($urandom_range(0, 31));
    return {upper, hdr_type};
  endfunction

  function automatic logic [7:0] noise_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return ZeroByte;
    if (pick < 60) return StartCodeByte;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_stream(int nal_count, bit noisy);
    int tail;
    int zeros;
    stream_q.delete();
    tail = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) add_payload($urandom_range(1, 3));
    if (noisy) begin
      repeat (nal_count * 4) stream_q.push_back(noise_byte());
    end else begin
      for (int i = 0; i < nal_count; i++) begin
        zeros = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(2, 3);
        add_start_code(zeros);
        stream_q.push_back(random_header());
        // end on a header now and then: closes one unit and opens the next
        if (!(i == nal_count - 1 && tail == 0)) add_payload($urandom_range(0, 8));
      end
      if (tail == 1 || tail == 2) add_start_code(tail + 1);
    end
  endfunction

  task automatic run_streams(int budget, int max_nals);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_stream($urandom_range(1, max_nals), $urandom_range(0, 9) == 0);
      sent += stream_q.size();
      send_stream();
    end
  endtask

  task automatic test_special_cases();
    // junk before the first code, 4-byte code with an extra zero, header on last byte
    stream_q = '{8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hff, 8'h00,
                 8'h00, 8'h01, 8'h65, 8'h80, 8'h00, 8'h00, 8'h01, 8'h41};
    send_stream();
    // zero header byte never starts a code; 01 on the last byte is plain data
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                 8'h01, 8'h25, 8'h00, 8'h00, 8'h01};
    send_stream();
    // end of stream with no unit open
    stream_q = '{8'hff};
    send_stream();
    wait_drained();
  endtask

  task automatic test_random_streams();
    write_reg(SkipCountAddr, '0);
    run_streams(300, 12);
    quiet_sender   = 1'b1;
    quiet_receiver = 1'b1;
    run_streams(150, 12);
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    // pause the source until the block has emitted everything
    wait_drained();
    run_streams(60, 40);
    wait_drained();
  endtask

  task automatic test_skip_gate();
    write_reg(SkipCountAddr, 32'd1);
    run_streams(100, 16);
    wait_drained();
    // bits above the register width are dropped
    write_reg(SkipCountAddr, 32'hfff0_0003);
    run_streams(100, 24);
    wait_drained();
    // unmapped index leaves the setting alone
    write_reg(UnmappedAddr, 32'd0);
    run_streams(60, 24);
    wait_drained();
    write_reg(SkipCountAddr, ApbDataW'(SkipMax));
    run_streams(40, 12);
    wait_drained();
    write_reg(SkipCountAddr, '0);
    run_streams(60, 12);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_request = LongStall;
    run_streams(200, 12);
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_stream = 1'b0;
    quiet_sender        = 1'b0;
    quiet_receiver      = 1'b0;
    hold_request        = 0;
    mismatch_count      = 0;
    skip_units          = '0;
    clear_parser();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_random_streams();
    test_skip_gate();
    test_backpressure();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/aus_pkg.sv
rtl/aus_in_if.sv
rtl/aus_out_if.sv
rtl/aus_fifo.sv
rtl/aus_parse.sv
rtl/annexb_access_unit_splitter.sv
dv/annexb_access_unit_splitter_tb.sv
